// ===== rtl/vfrq_pkg.sv =====
// Shared types, codes and helpers for the variable frame ring queue.
// No dependencies; imported by every module of the block but the ring RAM.
`default_nettype none

package vfrq_pkg;

    // Ring storage
    localparam int RING_WORDS = 1024;
    localparam int RING_AW    = $clog2(RING_WORDS);
    localparam int MAX_PAYLOAD_WORDS = 63;
    localparam int MAX_BYTES  = MAX_PAYLOAD_WORDS * 8;

    // Configuration register indexes and reset values
    localparam logic [1:0]  CFG_CAPACITY = 2'd0;
    localparam logic [1:0]  CFG_MAX_BYTES = 2'd1;
    localparam logic [10:0] CAP_RESET = 11'd16;
    localparam logic [8:0]  MAXB_RESET = 9'd504;

    // Header marker codes
    localparam logic [31:0] MARK_DATA = 32'd0;
    localparam logic [31:0] MARK_WRAP = 32'd1;

    // Input modes
    localparam logic [1:0] MODE_OPEN = 2'd0;
    localparam logic [1:0] MODE_WORD = 2'd1;
    localparam logic [1:0] MODE_RECV = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BLOCK      = 3'd1;
    localparam logic [2:0] ST_INVALID    = 3'd2;
    localparam logic [2:0] ST_BAD_MARKER = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd4;
    localparam logic [2:0] ST_BUF_SMALL  = 3'd5;
    localparam logic [2:0] ST_TOO_LARGE  = 3'd6;

    // One result item
    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] word;
        logic        has_word;
        logic [8:0]  bytes;
        logic        last;
    } result_t;

    // Ring geometry derived from configuration
    typedef struct packed {
        logic                 too_large;
        logic [RING_AW:0]     rw;
        logic [RING_AW-1:0]   mask;
        logic [8:0]           eff_max;
    } geom_t;

    // Payload words for a byte count (ceil of bytes / 8)
    function automatic logic [5:0] pay_words(logic [8:0] b);
        logic [9:0] s;
        begin
            s = {1'b0, b} + 10'd7;
            return s[8:3];
        end
    endfunction

    // Ring words = next power of two of frame words times capacity
    function automatic geom_t ring_geom(logic [10:0] cap, logic [8:0] maxb);
        geom_t      g;
        logic [8:0] mx;
        logic [6:0] fw;
        logic [17:0] target;
        logic [4:0] lg;
        begin
            mx = (maxb > 9'(MAX_BYTES)) ? 9'(MAX_BYTES) : maxb;
            fw = {1'b0, pay_words(mx)} + 7'd1;
            target = 18'(fw) * 18'(cap);
            lg = 5'd17;
            for (int i = 17; i >= 0; i--)
            begin
                if ((18'd1 << i) >= target)
                    lg = 5'(i);
            end
            g.eff_max = mx;
            g.too_large = (lg > 5'(RING_AW));
            if (g.too_large)
            begin
                g.rw = '0;
                g.mask = '0;
            end
            else
            begin
                g.rw = (RING_AW+1)'(1) << lg;
                g.mask = RING_AW'(g.rw - (RING_AW+1)'(1));
            end
            return g;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vfrq_ring_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
`default_nettype none

module vfrq_ring_ram #(
    parameter int AW = 10,
    parameter int DW = 64
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Read port, read data registered while re is high
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/vfrq_cfg.sv =====
// Configuration registers and registered ring geometry.
// Depends on vfrq_pkg.
`default_nettype none

module vfrq_cfg
    import vfrq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    output logic             cfg_clear,
    output geom_t            geom
);

    logic [10:0] cap_reg;
    logic [8:0]  maxb_reg;
    geom_t       geom_reg;

    // A write to a known register also clears the queue state
    assign cfg_clear = cfg_we && (cfg_index == CFG_CAPACITY || cfg_index == CFG_MAX_BYTES);
    assign geom = geom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CAP_RESET;
            maxb_reg <= MAXB_RESET;
            geom_reg <= ring_geom(CAP_RESET, MAXB_RESET);
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_CAPACITY)
                cap_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_MAX_BYTES)
                maxb_reg <= cfg_data[8:0];
            geom_reg <= ring_geom(cap_reg, maxb_reg);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vfrq_outq.sv =====
// Two-entry result queue: output register plus skid entry.
// Depends on vfrq_pkg.
`default_nettype none

module vfrq_outq
    import vfrq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  result_t      push_data,
    output logic         full,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      head
);

    logic    v0_reg, v1_reg;
    result_t e0_reg, e1_reg;
    logic    pop;

    assign pop = v0_reg && out_ready;
    assign full = v1_reg;
    assign out_valid = v0_reg;
    assign head = e0_reg;

    // Control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (pop)
        begin
            v0_reg <= v1_reg || push;
            v1_reg <= v1_reg && push;
        end
        else if (push)
        begin
            v0_reg <= 1'b1;
            v1_reg <= v0_reg;
        end
    end

    // Entry payloads
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e0_reg <= v1_reg ? e1_reg : push_data;
            if (v1_reg)
                e1_reg <= push_data;
        end
        else if (push)
        begin
            if (v0_reg)
                e1_reg <= push_data;
            else
                e0_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/variable_frame_ring_queue_unit.sv =====
// Top level of the variable frame ring queue: sequencer, positions, ring RAM.
// Depends on vfrq_pkg, vfrq_cfg, vfrq_outq, vfrq_ring_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one item: mode, payload_word,
//   byte_length. Output channel (out_valid/out_ready) gives result items.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); a
//   write to a known register clears both ring positions and any open send,
//   and the geometry is registered again from the written register. An open
//   that needs a wrap marker writes marker, then header (two writes on the
//   single ring write port). Send results enter the result queue as the item
//   is accepted. A receive checks each header in S_RX_CHK and S_RX_HDR (one
//   RAM read each, wrap markers skipped one per header), then reads payload
//   words one at a time through the registered RAM read and single read
//   port, reading the next only after the last is pushed. Results stream
//   out as words arrive, last marks the final word.
//   A two-entry result queue lets the next item be accepted while a result
//   waits; when the receiver stalls, the queue fills and input and RAM
//   reads hold until there is space.
//   Reset clears positions and the open send; ring contents are undefined
//   until written and no clearing pass is needed.
`default_nettype none

module variable_frame_ring_queue_unit
    import vfrq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [63:0] payload_word,
    input  wire logic [15:0] byte_length,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [63:0]      out_word,
    output logic             has_word,
    output logic [8:0]       message_bytes,
    output logic             last,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_RX_CHK,
        S_RX_HDR,
        S_RX_DATA
    } state_t;

    geom_t   geom;
    logic    cfg_clear;
    logic    q_full;
    logic    push;
    result_t res;
    result_t head;

    state_t state_reg, state_next;
    logic [31:0] wpos_reg, wpos_next;
    logic [31:0] rpos_reg, rpos_next;
    logic [31:0] pend_reg, pend_next;
    logic [5:0]  swl_reg, swl_next;
    logic [8:0]  ssize_reg, ssize_next;
    logic [RING_AW-1:0] hdr_addr_reg, hdr_addr_next;
    logic [8:0]  hdr_size_reg, hdr_size_next;
    logic [15:0] buf_reg, buf_next;
    logic [5:0]  rx_left_reg, rx_left_next;
    logic [31:0] rx_addr_reg, rx_addr_next;
    logic [8:0]  rx_bytes_reg, rx_bytes_next;
    logic        rd_pend_reg, rd_pend_next;
    logic        rd_last_reg, rd_last_next;

    logic        we;
    logic [RING_AW-1:0] waddr;
    logic [63:0] wdata;
    logic        re;
    logic [RING_AW-1:0] raddr;
    logic [63:0] rdata;

    logic        accept;
    logic [31:0] used32;
    logic [RING_AW:0] used, free, wcontig, rcontig;
    logic        over;
    logic [8:0]  clamp;
    logic [6:0]  ofw;
    logic [5:0]  opw;
    logic        wrap_needed;
    logic [31:0] open_base;
    logic [2:0]  rem;
    logic [63:0] keep;
    logic [5:0]  rpw;
    logic [6:0]  rfw;

    vfrq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_clear (cfg_clear),
        .geom      (geom)
    );

    vfrq_ring_ram #(
        .AW (RING_AW),
        .DW (64)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    vfrq_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .full      (q_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign status        = head.status;
    assign out_word      = head.word;
    assign has_word      = head.has_word;
    assign message_bytes = head.bytes;
    assign last          = head.last;

    assign in_ready = (state_reg == S_IDLE) && !q_full;
    assign accept   = in_valid && in_ready;

    // Occupancy and contiguous space
    assign used32  = wpos_reg - rpos_reg;
    assign used    = (used32 > 32'(geom.rw)) ? geom.rw : used32[RING_AW:0];
    assign free    = geom.rw - used;
    assign wcontig = geom.rw - {1'b0, wpos_reg[RING_AW-1:0] & geom.mask};
    assign rcontig = geom.rw - {1'b0, rpos_reg[RING_AW-1:0] & geom.mask};

    // Send open sizing
    assign over        = byte_length > {7'd0, geom.eff_max};
    assign clamp       = over ? geom.eff_max : byte_length[8:0];
    assign opw         = pay_words(byte_length[8:0]);
    assign ofw         = {1'b0, pay_words(clamp)} + 7'd1;
    assign wrap_needed = (RING_AW+1)'(ofw) > wcontig;
    assign open_base   = wrap_needed ? wpos_reg + 32'(wcontig) : wpos_reg;

    // Last payload word zero padding
    assign rem  = ssize_reg[2:0];
    assign keep = (64'd1 << {rem, 3'b000}) - 64'd1;

    // Receive header sizing
    assign rpw = pay_words(rdata[8:0]);
    assign rfw = {1'b0, rpw} + 7'd1;

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        wpos_next     = wpos_reg;
        rpos_next     = rpos_reg;
        pend_next     = pend_reg;
        swl_next      = swl_reg;
        ssize_next    = ssize_reg;
        hdr_addr_next = hdr_addr_reg;
        hdr_size_next = hdr_size_reg;
        buf_next      = buf_reg;
        rx_left_next  = rx_left_reg;
        rx_addr_next  = rx_addr_reg;
        rx_bytes_next = rx_bytes_reg;
        rd_pend_next  = 1'b0;
        rd_last_next  = rd_last_reg;
        push          = 1'b0;
        res.status    = ST_OK;
        res.word      = '0;
        res.has_word  = 1'b0;
        res.bytes     = '0;
        res.last      = 1'b1;
        we            = 1'b0;
        waddr         = wpos_reg[RING_AW-1:0] & geom.mask;
        wdata         = '0;
        re            = 1'b0;
        raddr         = rpos_reg[RING_AW-1:0] & geom.mask;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_OPEN:
                        begin
                            push = 1'b1;
                            if (geom.too_large)
                                res.status = ST_TOO_LARGE;
                            else
                            begin
                                swl_next = '0;
                                if (over || (RING_AW+1)'(ofw) > geom.rw)
                                begin
                                    res.status = ST_INVALID;
                                    res.bytes  = geom.eff_max;
                                end
                                else if ((wrap_needed &&
                                          {1'b0, free} < {1'b0, wcontig} + (RING_AW+2)'(ofw)) ||
                                         (!wrap_needed && free < (RING_AW+1)'(ofw)))
                                begin
                                    res.status = ST_BLOCK;
                                    res.bytes  = byte_length[8:0];
                                end
                                else
                                begin
                                    // Header now, or wrap marker now and header next cycle
                                    we = 1'b1;
                                    if (wrap_needed)
                                    begin
                                        wdata = {MARK_WRAP, 32'd0};
                                        wpos_next = open_base;
                                        hdr_addr_next = open_base[RING_AW-1:0] & geom.mask;
                                        hdr_size_next = byte_length[8:0];
                                        state_next = S_HDR;
                                    end
                                    else
                                        wdata = {MARK_DATA, 23'd0, byte_length[8:0]};
                                    pend_next  = open_base + 32'(ofw);
                                    swl_next   = opw;
                                    ssize_next = byte_length[8:0];
                                    if (opw == '0)
                                        wpos_next = open_base + 32'(ofw);
                                    res.bytes = byte_length[8:0];
                                end
                            end
                        end
                        MODE_WORD:
                        begin
                            push = 1'b1;
                            if (swl_reg == '0 || geom.too_large)
                                res.status = ST_INVALID;
                            else
                            begin
                                we = 1'b1;
                                waddr = RING_AW'(pend_reg - 32'(swl_reg)) & geom.mask;
                                wdata = payload_word;
                                if (swl_reg == 6'd1 && rem != 3'd0)
                                    wdata = payload_word & keep;
                                swl_next = swl_reg - 6'd1;
                                if (swl_reg == 6'd1)
                                    wpos_next = pend_reg;
                                res.bytes = ssize_reg;
                            end
                        end
                        MODE_RECV:
                        begin
                            if (geom.too_large)
                            begin
                                push = 1'b1;
                                res.status = ST_TOO_LARGE;
                            end
                            else
                            begin
                                buf_next = byte_length;
                                state_next = S_RX_CHK;
                            end
                        end
                        default:
                        begin
                            push = 1'b1;
                            res.status = ST_INVALID;
                        end
                    endcase
                end
            end
            S_HDR:
            begin
                we = 1'b1;
                waddr = hdr_addr_reg;
                wdata = {MARK_DATA, 23'd0, hdr_size_reg};
                state_next = S_IDLE;
            end
            S_RX_CHK:
            begin
                if (used32 == '0 || used32 > 32'(geom.rw))
                begin
                    push = 1'b1;
                    res.status = ST_BLOCK;
                    state_next = S_IDLE;
                end
                else
                begin
                    re = 1'b1;
                    state_next = S_RX_HDR;
                end
            end
            S_RX_HDR:
            begin
                if (rdata[63:32] == MARK_WRAP)
                begin
                    // Skip to ring start and look again
                    rpos_next = rpos_reg + 32'(rcontig);
                    state_next = S_RX_CHK;
                end
                else
                begin
                    state_next = S_IDLE;
                    push = 1'b1;
                    if (rdata[63:32] != MARK_DATA)
                        res.status = ST_BAD_MARKER;
                    else if (rdata[31:0] > 32'(geom.eff_max))
                        res.status = ST_BAD_SIZE;
                    else if ((RING_AW+1)'(rfw) > rcontig || 32'(rfw) > used32)
                        res.status = ST_BLOCK;
                    else if (rdata[15:0] > buf_reg)
                    begin
                        res.status = ST_BUF_SMALL;
                        res.bytes  = rdata[8:0];
                    end
                    else
                    begin
                        rpos_next = rpos_reg + 32'(rfw);
                        if (rpw != '0)
                        begin
                            push = 1'b0;
                            rx_left_next  = rpw;
                            rx_addr_next  = rpos_reg + 32'd1;
                            rx_bytes_next = rdata[8:0];
                            state_next    = S_RX_DATA;
                        end
                    end
                end
            end
            S_RX_DATA:
            begin
                if (rd_pend_reg)
                begin
                    push = 1'b1;
                    res.word     = rdata;
                    res.has_word = 1'b1;
                    res.bytes    = rx_bytes_reg;
                    res.last     = rd_last_reg;
                    if (rd_last_reg)
                        state_next = S_IDLE;
                end
                else if (rx_left_reg != '0 && !q_full)
                begin
                    re = 1'b1;
                    raddr = rx_addr_reg[RING_AW-1:0] & geom.mask;
                    rx_addr_next = rx_addr_reg + 32'd1;
                    rx_left_next = rx_left_reg - 6'd1;
                    rd_pend_next = 1'b1;
                    rd_last_next = (rx_left_reg == 6'd1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            wpos_reg    <= '0;
            rpos_reg    <= '0;
            pend_reg    <= '0;
            swl_reg     <= '0;
            ssize_reg   <= '0;
            rd_pend_reg <= 1'b0;
        end
        else if (cfg_clear)
        begin
            state_reg   <= S_IDLE;
            wpos_reg    <= '0;
            rpos_reg    <= '0;
            pend_reg    <= '0;
            swl_reg     <= '0;
            ssize_reg   <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wpos_reg    <= wpos_next;
            rpos_reg    <= rpos_next;
            pend_reg    <= pend_next;
            swl_reg     <= swl_next;
            ssize_reg   <= ssize_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    // Per-item working registers
    always_ff @(posedge clk)
    begin
        hdr_addr_reg <= hdr_addr_next;
        hdr_size_reg <= hdr_size_next;
        buf_reg      <= buf_next;
        rx_left_reg  <= rx_left_next;
        rx_addr_reg  <= rx_addr_next;
        rx_bytes_reg <= rx_bytes_next;
        rd_last_reg  <= rd_last_next;
    end

endmodule

`default_nettype wire

// ===== rtl/vfrq_checker.sv =====
// Port-level checks on the variable frame ring queue, bound to the top level.
// Depends on vfrq_pkg and variable_frame_ring_queue_unit.
`default_nettype none

module vfrq_port_checks
    import vfrq_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  status,
    input wire logic [63:0] out_word,
    input wire logic        has_word,
    input wire logic        last
);

    // No result while held in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // Payload words only come from a successful receive
    a_word_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_word |-> status == ST_OK)
        else $error("payload word with failing status");

    // A result without a word is alone: last set, word zero
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_word |-> last && out_word == 64'd0)
        else $error("non-word result not single");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(last))
        else $error("stalled result changed");

endmodule

bind variable_frame_ring_queue_unit vfrq_port_checks u_vfrq_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .out_word  (out_word),
    .has_word  (has_word),
    .last      (last)
);

`default_nettype wire

// ===== sim/vfrq_checker.sv =====
// Checker for the variable frame ring queue: watches both channels and the
// config port, predicts results in a ring mirror and compares. Uses vfrq_pkg.
`timescale 1ns / 1ps

module vfrq_checker
    import vfrq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [63:0] payload_word,
    input  wire logic [15:0] byte_length,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [2:0]  status,
    input  wire logic [63:0] out_word,
    input  wire logic        has_word,
    input  wire logic [8:0]  message_bytes,
    input  wire logic        last,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    output int               errors,
    output int               pending,
    output int               items_seen,
    output int               results_seen
);

    // Mirror of the ring and its positions
    logic [63:0] ring_mirror [0:RING_WORDS-1];
    int unsigned wr_pos, rd_pos, pend_pos, words_left, open_bytes;
    logic [10:0] capacity;
    logic [8:0]  max_bytes;
    result_t     expected_q [$];

    // Effective maximum payload bytes
    function automatic int unsigned eff_max();
        return (max_bytes > MAX_BYTES) ? MAX_BYTES : max_bytes;
    endfunction

    // Ring size; too_big set when it exceeds the RAM
    function automatic int unsigned ring_size(output bit too_big);
        longint unsigned target;
        longint unsigned p;
        begin
            target = (1 + (eff_max() + 7) / 8) * capacity;
            p = 1;
            while (p < target)
                p = p << 1;
            too_big = (p > RING_WORDS);
            return int'(p);
        end
    endfunction

    task automatic push(logic [2:0] st, logic [63:0] w, logic hw, logic [8:0] b, logic lst);
        result_t r;
        begin
            r.status = st;
            r.word = w;
            r.has_word = hw;
            r.bytes = b;
            r.last = lst;
            expected_q.insert(expected_q.size(), r);
        end
    endtask

    // Send open: space checks, optional wrap marker, header write
    task automatic predict_open(int unsigned len);
        int unsigned rw, mx, sz, fw, w, used, freew, contig;
        bit big;
        begin
            rw = ring_size(big);
            mx = eff_max();
            if (big)
            begin
                push(ST_TOO_LARGE, '0, 1'b0, '0, 1'b1);
                return;
            end
            words_left = 0;
            sz = (len > mx) ? mx : len;
            fw = 1 + (sz + 7) / 8;
            if (len > mx || fw > rw)
            begin
                push(ST_INVALID, '0, 1'b0, 9'(mx), 1'b1);
                return;
            end
            w = wr_pos;
            used = wr_pos - rd_pos;
            if (used > rw)
                used = rw;
            freew = rw - used;
            contig = rw - (w & (rw - 1));
            if (contig < fw)
            begin
                if (freew < contig + fw)
                begin
                    push(ST_BLOCK, '0, 1'b0, 9'(len), 1'b1);
                    return;
                end
                ring_mirror[w & (rw - 1)] = {MARK_WRAP, 32'd0};
                w = w + contig;
                wr_pos = w;
                used = wr_pos - rd_pos;
                if (used > rw)
                    used = rw;
                freew = rw - used;
                if (freew < fw)
                begin
                    push(ST_BLOCK, '0, 1'b0, 9'(len), 1'b1);
                    return;
                end
            end
            else if (freew < fw)
            begin
                push(ST_BLOCK, '0, 1'b0, 9'(len), 1'b1);
                return;
            end
            ring_mirror[w & (rw - 1)] = {MARK_DATA, len};
            pend_pos = w + fw;
            words_left = (len + 7) / 8;
            open_bytes = len;
            if (words_left == 0)
                wr_pos = pend_pos;
            push(ST_OK, '0, 1'b0, 9'(len), 1'b1);
        end
    endtask

    // Send payload word; the final word is masked to the message size
    task automatic predict_word(logic [63:0] word);
        int unsigned rw, rem;
        bit big;
        logic [63:0] w;
        begin
            rw = ring_size(big);
            w = word;
            if (words_left == 0 || big)
            begin
                push(ST_INVALID, '0, 1'b0, '0, 1'b1);
                return;
            end
            if (words_left == 1)
            begin
                rem = open_bytes & 7;
                if (rem != 0)
                    w = w & ((64'd1 << (rem * 8)) - 64'd1);
            end
            ring_mirror[(pend_pos - words_left) & (rw - 1)] = w;
            words_left = words_left - 1;
            if (words_left == 0)
                wr_pos = pend_pos;
            push(ST_OK, '0, 1'b0, 9'(open_bytes), 1'b1);
        end
    endtask

    // Receive: skip wrap markers, check header, emit payload words
    task automatic predict_recv(int unsigned buf_len);
        int unsigned rw, mx, avail, contig, req, fw, n;
        logic [63:0] h;
        bit big;
        begin
            rw = ring_size(big);
            mx = eff_max();
            if (big)
            begin
                push(ST_TOO_LARGE, '0, 1'b0, '0, 1'b1);
                return;
            end
            forever
            begin
                avail = wr_pos - rd_pos;
                if (avail == 0 || avail > rw)
                begin
                    push(ST_BLOCK, '0, 1'b0, '0, 1'b1);
                    return;
                end
                contig = rw - (rd_pos & (rw - 1));
                h = ring_mirror[rd_pos & (rw - 1)];
                if (h[63:32] != MARK_WRAP)
                    break;
                rd_pos = rd_pos + contig;
            end
            if (h[63:32] != MARK_DATA)
            begin
                push(ST_BAD_MARKER, '0, 1'b0, '0, 1'b1);
                return;
            end
            req = h[31:0];
            if (req > mx)
            begin
                push(ST_BAD_SIZE, '0, 1'b0, '0, 1'b1);
                return;
            end
            fw = 1 + (req + 7) / 8;
            if (fw > contig || fw > avail)
            begin
                push(ST_BLOCK, '0, 1'b0, '0, 1'b1);
                return;
            end
            if (req > buf_len)
            begin
                push(ST_BUF_SMALL, '0, 1'b0, 9'(req), 1'b1);
                return;
            end
            n = (req + 7) / 8;
            if (n == 0)
                push(ST_OK, '0, 1'b0, '0, 1'b1);
            for (int unsigned i = 0; i < n; i++)
                push(ST_OK, ring_mirror[(rd_pos + 1 + i) & (rw - 1)], 1'b1, 9'(req),
                     (i + 1 == n));
            rd_pos = rd_pos + fw;
        end
    endtask

    // Channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            wr_pos = 0;
            rd_pos = 0;
            pend_pos = 0;
            words_left = 0;
            open_bytes = 0;
            capacity = CAP_RESET;
            max_bytes = MAXB_RESET;
            errors = 0;
            items_seen = 0;
            results_seen = 0;
            expected_q.delete();
            for (int i = 0; i < RING_WORDS; i++)
                ring_mirror[i] = '0;
        end
        else
        begin
            // config write clears positions and the open send
            if (cfg_we && (cfg_index == CFG_CAPACITY || cfg_index == CFG_MAX_BYTES))
            begin
                if (cfg_index == CFG_CAPACITY)
                    capacity = cfg_data;
                else
                    max_bytes = cfg_data[8:0];
                wr_pos = 0;
                rd_pos = 0;
                pend_pos = 0;
                words_left = 0;
                open_bytes = 0;
            end
            // result compare against the oldest expectation
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result item: status %0d word %0h", status, out_word);
                    errors++;
                end
                else
                begin
                    e = expected_q[0];
                    expected_q.delete(0);
                    if (status !== e.status)
                    begin
                        $error("status: expected %0d got %0d", e.status, status);
                        errors++;
                    end
                    if (out_word !== e.word)
                    begin
                        $error("out_word: expected %0h got %0h", e.word, out_word);
                        errors++;
                    end
                    if (has_word !== e.has_word)
                    begin
                        $error("has_word: expected %0d got %0d", e.has_word, has_word);
                        errors++;
                    end
                    if (message_bytes !== e.bytes)
                    begin
                        $error("message_bytes: expected %0d got %0d", e.bytes, message_bytes);
                        errors++;
                    end
                    if (last !== e.last)
                    begin
                        $error("last: expected %0d got %0d", e.last, last);
                        errors++;
                    end
                end
            end
            // accepted input item
            if (in_valid && in_ready)
            begin
                items_seen++;
                if (mode == MODE_OPEN)
                    predict_open(byte_length);
                else if (mode == MODE_WORD)
                    predict_word(payload_word);
                else if (mode == MODE_RECV)
                    predict_recv(byte_length);
                else
                    push(ST_INVALID, '0, 1'b0, '0, 1'b1);
            end
        end
        pending = expected_q.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for variable_frame_ring_queue_unit: clock, reset, stimulus
// and verdict. Depends on vfrq_pkg, the block and vfrq_checker.
`timescale 1ns / 1ps

module tb_top;
    import vfrq_pkg::*;

    localparam int CYCLE_LIMIT = 100000;

    // Mode and register index outside the defined set
    localparam logic [1:0] MODE_RSVD  = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [63:0] payload_word;
    logic [15:0] byte_length;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [63:0] out_word;
    logic        has_word;
    logic [8:0]  message_bytes;
    logic        last;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;

    int errors, pending, items_seen, results_seen;
    int cycles;
    int settings_used;
    bit quiet;
    bit hold_req;
    int cur_max;

    variable_frame_ring_queue_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .payload_word(payload_word), .byte_length(byte_length),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .out_word(out_word), .has_word(has_word),
        .message_bytes(message_bytes), .last(last),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    vfrq_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .payload_word(payload_word), .byte_length(byte_length),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .out_word(out_word), .has_word(has_word),
        .message_bytes(message_bytes), .last(last),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending),
        .items_seen(items_seen), .results_seen(results_seen)
    );

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off, none at the end
    initial
    begin
        bit held;
        held = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                out_ready = 1'b0;
                repeat (400) @(negedge clk);
                out_ready = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_ready = 1'b1;
            end
            else
                out_ready = 1'b1;
        end
    end

    // Offer one item and wait until it is taken; valid stays high after
    task automatic send_item(logic [1:0] m, logic [63:0] w, logic [15:0] len);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid = 1'b1;
        mode = m;
        payload_word = w;
        byte_length = len;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Register write once the block has drained
    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        repeat (2) @(negedge clk);
    endtask

    task automatic set_ring(logic [10:0] cap, logic [8:0] maxb);
        write_reg(CFG_CAPACITY, cap);
        write_reg(CFG_MAX_BYTES, {2'b00, maxb});
        cur_max = (maxb > MAX_BYTES) ? MAX_BYTES : maxb;
        settings_used++;
    endtask

    // One whole message: open plus its payload words
    task automatic send_message(int unsigned len, logic [63:0] fill);
        send_item(MODE_OPEN, rand_word(), 16'(len));
        for (int unsigned i = 0; i < (len + 7) / 8; i++)
            send_item(MODE_WORD, (fill == '1) ? fill : rand_word(), 16'($urandom));
    endtask

    // Random traffic, mostly well-formed messages and receives
    task automatic random_traffic(int n);
        int r;
        int unsigned len, nw;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(0, 65535);
                else
                    len = $urandom_range(0, cur_max);
                send_item(MODE_OPEN, rand_word(), 16'(len));
                nw = (len <= cur_max) ? (len + 7) / 8 : 0;
                if (nw > 0 && $urandom_range(0, 9) == 0)
                    nw = $urandom_range(0, nw - 1);
                for (int unsigned i = 0; i < nw; i++)
                    send_item(MODE_WORD, rand_word(), 16'($urandom));
            end
            else if (r < 85)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_item(MODE_RECV, rand_word(), 16'($urandom_range(0, cur_max)));
                else
                    send_item(MODE_RECV, rand_word(), 16'($urandom_range(cur_max, 65535)));
            end
            else if (r < 93)
                send_item(MODE_WORD, rand_word(), 16'($urandom));
            else
                send_item(MODE_RSVD, rand_word(), 16'($urandom));
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        cycles = 0;
        settings_used = 1;
        quiet = 1'b0;
        hold_req = 1'b0;
        cur_max = MAX_BYTES;
        in_valid = 1'b0;
        mode = MODE_OPEN;
        payload_word = '0;
        byte_length = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_CAPACITY;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: default ring of 1024 words
        send_item(MODE_RECV, '0, 16'hFFFF);              // empty ring
        send_message(0, '0);                             // zero-length message
        send_item(MODE_RECV, '0, 16'd0);
        send_message(40, '1);
        send_item(MODE_RECV, '0, 16'd39);                // buffer too small
        send_item(MODE_RECV, '0, 16'hFFFF);
        send_message(13, '1);                            // final word masked
        send_item(MODE_RECV, '0, 16'd13);
        send_item(MODE_OPEN, '0, 16'd505);               // over the maximum
        send_item(MODE_OPEN, '0, 16'hFFFF);
        send_item(MODE_WORD, '1, 16'd0);                 // no open send
        send_item(MODE_RSVD, '0, 16'd0);                 // reserved mode
        send_item(MODE_OPEN, '0, 16'd20);                // abandoned by next open
        send_message(8, '0);
        send_item(MODE_RECV, '0, 16'd8);

        // directed: 8-word ring, wrap marker and full ring
        set_ring(11'd2, 9'd24);
        send_message(24, '0);
        send_item(MODE_RECV, '0, 16'd23);
        send_item(MODE_RECV, '0, 16'd24);
        send_message(16, '0);
        send_item(MODE_RECV, '0, 16'd16);
        send_message(16, '0);                            // needs a wrap
        send_message(24, '0);                            // fills the ring
        send_item(MODE_OPEN, '0, 16'd0);                 // ring full
        send_item(MODE_RECV, '0, 16'd24);                // skips the wrap marker
        send_item(MODE_RECV, '0, 16'd24);
        random_traffic(8);

        // long receiver hold-off while items keep coming
        set_ring(11'd16, 9'd64);
        hold_req = 1'b1;
        random_traffic(10);

        set_ring(11'd3, 9'd40);
        random_traffic(8);

        set_ring(11'd0, 9'd1);                           // single-word ring
        send_message(0, '0);
        send_item(MODE_OPEN, '0, 16'd1);
        random_traffic(5);

        set_ring(11'd1024, 9'd504);                      // ring too large
        send_item(MODE_OPEN, '0, 16'd8);
        send_item(MODE_WORD, '0, 16'd0);
        send_item(MODE_RECV, '0, 16'hFFFF);

        set_ring(11'd2047, 9'd0);                        // still too large
        send_item(MODE_OPEN, '0, 16'd0);
        send_item(MODE_RECV, '0, 16'd0);

        write_reg(CFG_UNUSED, 11'h7FF);                  // unused index
        set_ring(11'd1024, 9'd0);                        // 1024 one-word frames
        random_traffic(8);

        set_ring(11'd8, 9'd511);                         // max clamps to 504
        send_item(MODE_OPEN, '0, 16'd505);
        send_message(0, '0);
        send_item(MODE_RECV, '0, 16'd0);

        // last part: no idling on either side
        quiet = 1'b1;
        set_ring(11'd5, 9'd24);
        random_traffic(15);

        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("ran %0d items and %0d results across %0d ring settings",
                 items_seen, results_seen, settings_used);
        $display("covered sends, wraps, full ring, receives and error statuses");
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== variable_frame_ring_queue_unit.f =====
rtl/vfrq_pkg.sv
rtl/vfrq_ring_ram.sv
rtl/vfrq_cfg.sv
rtl/vfrq_outq.sv
rtl/variable_frame_ring_queue_unit.sv
rtl/vfrq_checker.sv
sim/vfrq_checker.sv
sim/tb_top.sv
